[design/ps2_wheel_mouse_packet_decoder_core_assert.svh]
// Assertion macros for the PS/2 wheel mouse decoder.
`ifndef PS2_WHEEL_MOUSE_PACKET_DECODER_CORE_ASSERT_SVH
`define PS2_WHEEL_MOUSE_PACKET_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define PS2WM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2wm: same-cycle check failed");
`define PS2WM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2wm: next-cycle check failed");
`else
`define PS2WM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PS2WM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[design/ps2wm_pkg.sv]
package ps2wm_pkg;

    localparam logic [7:0] ACK_BYTE     = 8'hFA;
    localparam logic [7:0] SYNC_MASK    = 8'hC8;
    localparam logic [7:0] SYNC_VALUE   = 8'h08;
    localparam logic [7:0] CMD_SET_RATE = 8'hF3;
    localparam logic [7:0] CMD_GET_ID   = 8'hF2;
    localparam logic [7:0] RATE_200     = 8'd200;
    localparam logic [7:0] RATE_100     = 8'd100;
    localparam logic [7:0] RATE_80      = 8'd80;
    localparam logic [7:0] ID_NO_WHEEL  = 8'h00;

    localparam int X_SIGN_BIT  = 4;
    localparam int Y_SIGN_BIT  = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        PH_INIT      = 4'd0,
        PH_P3_STATUS = 4'd1,
        PH_P3_X      = 4'd2,
        PH_P3_Y      = 4'd3,
        PH_RATE100   = 4'd4,
        PH_RATE80    = 4'd5,
        PH_GETID     = 4'd6,
        PH_READID    = 4'd7,
        PH_P4_STATUS = 4'd8,
        PH_P4_X      = 4'd9,
        PH_P4_Y      = 4'd10,
        PH_P4_WHEEL  = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        OP_SET_RATE = 2'd0,
        OP_GET_ID   = 2'd1,
        OP_REPORT   = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] rate;
        logic [7:0] status;
        logic [7:0] x;
        logic [7:0] y;
        logic [3:0] wheel;
    } t_job;

endpackage

[design/ps2wm_front.sv]
module ps2wm_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_q_full,
    output logic             o_job_valid,
    output ps2wm_pkg::t_job  o_job
);
    import ps2wm_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_first_byte, n_first_byte;
    logic [7:0] r_x_byte, n_x_byte;
    logic [7:0] r_y_byte, n_y_byte;
    logic [3:0] r_wheel_value, n_wheel_value;

    logic accept;
    logic is_ack;
    logic is_sync;

    assign accept  = i_push && !i_q_full;
    assign is_ack  = (i_rx_byte == ACK_BYTE);
    assign is_sync = ((i_rx_byte & SYNC_MASK) == SYNC_VALUE);

    // Next state
    always_comb begin
        n_phase       = r_phase;
        n_first_byte  = r_first_byte;
        n_x_byte      = r_x_byte;
        n_y_byte      = r_y_byte;
        n_wheel_value = r_wheel_value;
        if (accept) begin
            unique case (r_phase)
                PH_INIT: begin
                    if (is_ack) n_phase = PH_RATE100;
                end
                PH_RATE100: begin
                    if (is_ack) n_phase = PH_RATE80;
                end
                PH_RATE80: begin
                    if (is_ack) n_phase = PH_GETID;
                end
                PH_GETID: begin
                    if (is_ack) n_phase = PH_READID;
                end
                PH_READID: begin
                    if (!is_ack) begin
                        if (i_rx_byte == ID_NO_WHEEL) begin
                            n_wheel_value = '0;
                            n_phase       = PH_P3_STATUS;
                        end else begin
                            n_phase = PH_P4_STATUS;
                        end
                    end
                end
                PH_P3_STATUS: begin
                    if (is_sync) begin
                        n_first_byte = i_rx_byte;
                        n_phase      = PH_P3_X;
                    end
                end
                PH_P3_X: begin
                    n_x_byte = i_rx_byte;
                    n_phase  = PH_P3_Y;
                end
                PH_P3_Y: begin
                    n_y_byte = i_rx_byte;
                    n_phase  = PH_P3_STATUS;
                end
                PH_P4_STATUS: begin
                    if (is_sync) begin
                        n_first_byte = i_rx_byte;
                        n_phase      = PH_P4_X;
                    end
                end
                PH_P4_X: begin
                    n_x_byte = i_rx_byte;
                    n_phase  = PH_P4_Y;
                end
                PH_P4_Y: begin
                    n_y_byte = i_rx_byte;
                    n_phase  = PH_P4_WHEEL;
                end
                PH_P4_WHEEL: begin
                    n_wheel_value = i_rx_byte[3:0];
                    n_phase       = PH_P4_STATUS;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Job for the back end; the final byte of a packet bypasses its register
    always_comb begin
        o_job_valid  = 1'b0;
        o_job.op     = OP_REPORT;
        o_job.rate   = RATE_200;
        o_job.status = r_first_byte;
        o_job.x      = r_x_byte;
        o_job.y      = r_y_byte;
        o_job.wheel  = r_wheel_value;
        if (accept) begin
            unique case (r_phase)
                PH_INIT: begin
                    o_job_valid = 1'b1;
                    o_job.op    = OP_SET_RATE;
                    o_job.rate  = RATE_200;
                end
                PH_RATE100: begin
                    o_job_valid = 1'b1;
                    o_job.op    = OP_SET_RATE;
                    o_job.rate  = RATE_100;
                end
                PH_RATE80: begin
                    o_job_valid = 1'b1;
                    o_job.op    = OP_SET_RATE;
                    o_job.rate  = RATE_80;
                end
                PH_GETID: begin
                    o_job_valid = 1'b1;
                    o_job.op    = OP_GET_ID;
                end
                PH_P3_Y: begin
                    o_job_valid = 1'b1;
                    o_job.y     = i_rx_byte;
                end
                PH_P4_WHEEL: begin
                    o_job_valid = 1'b1;
                    o_job.wheel = i_rx_byte[3:0];
                end
                default: begin
                    o_job_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_INIT;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_byte  <= n_first_byte;
        r_x_byte      <= n_x_byte;
        r_y_byte      <= n_y_byte;
        r_wheel_value <= n_wheel_value;
    end

endmodule

[design/ps2wm_fifo.sv]
module ps2wm_fifo #(
    parameter int DEPTH = ps2wm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ps2wm_pkg::t_job  i_data,
    output logic             o_full,
    output logic             o_valid,
    output ps2wm_pkg::t_job  o_data,
    input  logic             i_pop
);
    import ps2wm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          push_fire;
    logic          pop_fire;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign push_fire = i_push && !o_full;
    assign pop_fire  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_fire) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_fire) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_fire && !pop_fire) begin
            n_count = r_count + 1'b1;
        end else if (pop_fire && !push_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/ps2wm_back.sv]
module ps2wm_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  ps2wm_pkg::t_job    i_job,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic               o_kind,
    output logic [7:0]         o_command_byte,
    output logic [7:0]         o_status_byte,
    output logic signed [8:0]  o_delta_x,
    output logic signed [9:0]  o_delta_y,
    output logic signed [3:0]  o_wheel,
    output logic               o_last
);
    import ps2wm_pkg::*;

    logic              r_valid;
    logic              r_second, n_second;
    logic              r_kind, n_kind;
    logic [7:0]        r_command_byte, n_command_byte;
    logic [7:0]        r_status_byte, n_status_byte;
    logic signed [8:0] r_delta_x, n_delta_x;
    logic signed [9:0] r_delta_y, n_delta_y;
    logic signed [3:0] r_wheel, n_wheel;
    logic              r_last, n_last;
    logic              load;
    logic [9:0]        y_ext;

    // Take the next result whenever the output register is free or being drained
    assign load  = i_job_valid && (!r_valid || i_pop);
    assign y_ext = {{2{i_job.status[Y_SIGN_BIT]}}, i_job.y};

    always_comb begin
        n_second       = 1'b0;
        n_kind         = 1'b0;
        n_command_byte = '0;
        n_status_byte  = '0;
        n_delta_x      = '0;
        n_delta_y      = '0;
        n_wheel        = '0;
        n_last         = 1'b1;
        unique case (i_job.op)
            OP_SET_RATE: begin
                // Send the set-rate command, then the rate on the next slot
                n_command_byte = r_second ? i_job.rate : CMD_SET_RATE;
                n_last         = r_second;
                n_second       = !r_second;
            end
            OP_GET_ID: begin
                n_command_byte = CMD_GET_ID;
            end
            OP_REPORT: begin
                n_kind        = 1'b1;
                n_status_byte = i_job.status;
                n_delta_x     = $signed({i_job.status[X_SIGN_BIT], i_job.x});
                n_delta_y     = $signed(10'(10'd0 - y_ext));
                n_wheel       = $signed(i_job.wheel);
            end
            default: begin
                n_last = 1'b1;
            end
        endcase
    end

    // Retire the job only with its final result
    assign o_job_pop = load && n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_second <= n_second;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind         <= n_kind;
            r_command_byte <= n_command_byte;
            r_status_byte  <= n_status_byte;
            r_delta_x      <= n_delta_x;
            r_delta_y      <= n_delta_y;
            r_wheel        <= n_wheel;
            r_last         <= n_last;
        end
    end

    assign o_empty        = !r_valid;
    assign o_kind         = r_kind;
    assign o_command_byte = r_command_byte;
    assign o_status_byte  = r_status_byte;
    assign o_delta_x      = r_delta_x;
    assign o_delta_y      = r_delta_y;
    assign o_wheel        = r_wheel;
    assign o_last         = r_last;

endmodule

[design/ps2_wheel_mouse_packet_decoder_core.sv]
// Path: an accepted byte's job is registered in the job queue, then in the output register.
// Throughput: one byte per cycle in unless full; one result per cycle out while popped.
// Set-rate steps give two results per byte, which the output register delivers in turn.
// A job queue of QUEUE_DEPTH entries sits between the byte decoder and the result stage.
// Reset (synchronous, active low) returns to waiting for the enable acknowledge.
`include "ps2_wheel_mouse_packet_decoder_core_assert.svh"

module ps2_wheel_mouse_packet_decoder_core #(
    parameter int QUEUE_DEPTH = ps2wm_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    output logic               empty,
    input  logic               pop,
    output logic               o_kind,
    output logic [7:0]         o_command_byte,
    output logic [7:0]         o_status_byte,
    output logic signed [8:0]  o_delta_x,
    output logic signed [9:0]  o_delta_y,
    output logic signed [3:0]  o_wheel,
    output logic               o_last
);
    import ps2wm_pkg::*;

    logic q_full;
    logic fr_job_valid;
    t_job fr_job;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    assign full = q_full;

    ps2wm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (q_full),
        .o_job_valid (fr_job_valid),
        .o_job       (fr_job)
    );

    ps2wm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_job_valid),
        .i_data  (fr_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_job),
        .i_pop   (q_pop)
    );

    ps2wm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .o_job_pop      (q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_kind         (o_kind),
        .o_command_byte (o_command_byte),
        .o_status_byte  (o_status_byte),
        .o_delta_x      (o_delta_x),
        .o_delta_y      (o_delta_y),
        .o_wheel        (o_wheel),
        .o_last         (o_last)
    );

    // A set-rate command byte must be followed at once by its rate byte
    `PS2WM_ASSERT_NEXT(a_rate_follows, i_clk, i_rst_n, (!empty && !o_last && pop), !empty)
    // Only the set-rate command ever leaves a transaction open
    `PS2WM_ASSERT_IMPL(a_open_is_set_rate, i_clk, i_rst_n, (!empty && !o_last), (o_kind == 1'b0 && o_command_byte == CMD_SET_RATE))
    // A report is always the single result of its byte
    `PS2WM_ASSERT_IMPL(a_report_last, i_clk, i_rst_n, (!empty && o_kind), o_last)

endmodule
